[src/mbtf_pkg.sv]
package mbtf_pkg;

    // Input modes
    localparam logic [2:0] MODE_READ     = 3'd0;
    localparam logic [2:0] MODE_WR_SINGLE = 3'd1;
    localparam logic [2:0] MODE_WR_MULTI = 3'd2;
    localparam logic [2:0] MODE_DATA     = 3'd3;
    localparam logic [2:0] MODE_RESP     = 3'd4;

    // Result kinds
    localparam logic [1:0] KIND_TX     = 2'd0;
    localparam logic [1:0] KIND_WORD   = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // Completion status codes
    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_ID        = 3'd1;
    localparam logic [2:0] STAT_EXC       = 3'd2;
    localparam logic [2:0] STAT_FUNC      = 3'd3;
    localparam logic [2:0] STAT_COUNT     = 3'd4;
    localparam logic [2:0] STAT_QUANTITY  = 3'd5;

    // Function codes and the exception flag of the function byte
    localparam logic [7:0] FC_READ_HOLDING = 8'h03;
    localparam logic [7:0] FC_WRITE_SINGLE = 8'h06;
    localparam logic [7:0] FC_WRITE_MULTI  = 8'h10;
    localparam logic [7:0] FC_EXC_BIT      = 8'h80;

    typedef struct packed {
        logic [2:0]  mode;
        logic [15:0] address;
        logic [15:0] operand;
        logic [7:0]  rx_byte;
    } t_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  tx_byte;
        logic [15:0] reg_word;
        logic [2:0]  status;
        logic [7:0]  exception_code;
        logic        last;
    } t_result;

    // Work orders passed from the front end to the back end through the queue.
    typedef enum logic [2:0] {
        OP_READ,
        OP_WR_SINGLE,
        OP_WR_MULTI,
        OP_DATA,
        OP_WORD,
        OP_STATUS,
        OP_WORD_STATUS
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [15:0] tid;
        logic [7:0]  unit_id;
        logic [15:0] addr;
        logic [15:0] opd;
        logic [2:0]  status;
        logic [7:0]  exc;
        logic        last;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_push;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_head;

endpackage

[src/mbtf_front.sv]
module mbtf_front #(
    parameter int MAX_READ_REGS  = 125,
    parameter int MAX_WRITE_REGS = 123
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_valid,
    input  logic [7:0]      i_cfg_data,
    output logic            o_cfg_ready,
    input  logic            i_in_valid,
    input  mbtf_pkg::t_item i_in_data,
    output logic            o_in_stall,
    input  logic            i_full,
    output mbtf_pkg::t_push o_push
);
    import mbtf_pkg::*;

    localparam logic [1:0] PK_NONE = 2'd0;
    localparam logic [1:0] PK_READ = 2'd1;

    localparam logic [3:0] IDX_TID_HI = 4'd0;
    localparam logic [3:0] IDX_TID_LO = 4'd1;
    localparam logic [3:0] IDX_FC     = 4'd7;
    localparam logic [3:0] IDX_BC     = 4'd8;
    localparam logic [3:0] IDX_HI     = 4'd9;
    localparam logic [3:0] IDX_LO     = 4'd10;
    localparam logic [3:0] IDX_WR_END = 4'd11;

    logic [7:0]  r_unit_id;
    logic [15:0] r_next_tid,  n_next_tid;
    logic [15:0] r_pend_tid,  n_pend_tid;
    logic [1:0]  r_pend_kind, n_pend_kind;
    logic [6:0]  r_exp_words, n_exp_words;
    logic [3:0]  r_resp_idx,  n_resp_idx;
    logic [2:0]  r_err,       n_err;
    logic [7:0]  r_exc,       n_exc;
    logic [7:0]  r_hold,      n_hold;
    logic [6:0]  r_words_left, n_words_left;

    logic  accept;
    logic  is_read;
    logic  word_out;
    logic  done;
    t_push push;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = i_full;
    assign accept      = i_in_valid && !i_full;
    assign is_read     = (r_pend_kind == PK_READ);

    always_comb begin
        n_next_tid   = r_next_tid;
        n_pend_tid   = r_pend_tid;
        n_pend_kind  = r_pend_kind;
        n_exp_words  = r_exp_words;
        n_resp_idx   = r_resp_idx;
        n_err        = r_err;
        n_exc        = r_exc;
        n_hold       = r_hold;
        n_words_left = r_words_left;
        word_out     = 1'b0;
        done         = 1'b0;

        push.valid        = 1'b0;
        push.cmd.op       = OP_STATUS;
        push.cmd.tid      = r_next_tid;
        push.cmd.unit_id  = r_unit_id;
        push.cmd.addr     = i_in_data.address;
        push.cmd.opd      = i_in_data.operand;
        push.cmd.status   = STAT_OK;
        push.cmd.exc      = 8'h00;
        push.cmd.last     = 1'b0;

        case (i_in_data.mode)
            MODE_READ, MODE_WR_SINGLE, MODE_WR_MULTI: begin
                push.valid = 1'b1;
                if ((i_in_data.mode == MODE_READ &&
                     (i_in_data.operand == 16'd0 ||
                      i_in_data.operand > 16'(MAX_READ_REGS))) ||
                    (i_in_data.mode == MODE_WR_MULTI &&
                     (i_in_data.operand == 16'd0 ||
                      i_in_data.operand > 16'(MAX_WRITE_REGS)))) begin
                    push.cmd.op     = OP_STATUS;
                    push.cmd.status = STAT_QUANTITY;
                end else begin
                    if (i_in_data.mode == MODE_READ) begin
                        push.cmd.op = OP_READ;
                    end else if (i_in_data.mode == MODE_WR_SINGLE) begin
                        push.cmd.op = OP_WR_SINGLE;
                    end else begin
                        push.cmd.op = OP_WR_MULTI;
                    end
                    // A new request abandons whatever response was still being tracked.
                    n_pend_tid   = r_next_tid;
                    n_next_tid   = r_next_tid + 16'd1;
                    n_pend_kind  = i_in_data.mode[1:0] + 2'd1;
                    n_exp_words  = (i_in_data.mode == MODE_READ) ?
                                   i_in_data.operand[6:0] : 7'd0;
                    n_words_left = (i_in_data.mode == MODE_WR_MULTI) ?
                                   i_in_data.operand[6:0] : 7'd0;
                    n_resp_idx   = 4'd0;
                    n_err        = STAT_OK;
                    n_exc        = 8'h00;
                    n_hold       = 8'h00;
                end
            end
            MODE_DATA: begin
                if (r_words_left != 7'd0) begin
                    n_words_left  = r_words_left - 7'd1;
                    push.valid    = 1'b1;
                    push.cmd.op   = OP_DATA;
                    push.cmd.last = (r_words_left == 7'd1);
                end
            end
            MODE_RESP: begin
                if (r_pend_kind != PK_NONE && r_words_left == 7'd0) begin
                    if (r_resp_idx == IDX_TID_HI) begin
                        n_hold = i_in_data.rx_byte;
                    end else if (r_resp_idx == IDX_TID_LO) begin
                        if ({r_hold, i_in_data.rx_byte} != r_pend_tid) begin
                            n_err = STAT_ID;
                        end
                    end else if (r_resp_idx == IDX_FC) begin
                        if (r_err == STAT_OK) begin
                            if ((i_in_data.rx_byte & FC_EXC_BIT) != 8'h00) begin
                                n_err = STAT_EXC;
                            end else if (is_read &&
                                         i_in_data.rx_byte != FC_READ_HOLDING) begin
                                n_err = STAT_FUNC;
                            end
                        end
                    end else if (r_resp_idx == IDX_BC) begin
                        if (r_err == STAT_EXC) begin
                            n_exc = i_in_data.rx_byte;
                        end else if (r_err == STAT_OK && is_read &&
                                     i_in_data.rx_byte != {r_exp_words, 1'b0}) begin
                            n_err = STAT_COUNT;
                        end
                    end else if (is_read && r_resp_idx == IDX_HI) begin
                        n_hold = i_in_data.rx_byte;
                    end else if (is_read && r_resp_idx == IDX_LO) begin
                        word_out = (r_err == STAT_OK);
                    end

                    if (is_read) begin
                        if (r_resp_idx < IDX_BC) begin
                            n_resp_idx = r_resp_idx + 4'd1;
                        end else if (r_resp_idx == IDX_BC) begin
                            if (r_exp_words == 7'd0) begin
                                done = 1'b1;
                            end else begin
                                n_resp_idx = IDX_HI;
                            end
                        end else if (r_resp_idx == IDX_HI) begin
                            n_resp_idx = IDX_LO;
                        end else begin
                            if (r_exp_words != 7'd0) begin
                                n_exp_words = r_exp_words - 7'd1;
                            end
                            if (n_exp_words == 7'd0) begin
                                done = 1'b1;
                            end else begin
                                n_resp_idx = IDX_HI;
                            end
                        end
                    end else begin
                        if (r_resp_idx >= IDX_WR_END) begin
                            done = 1'b1;
                        end else begin
                            n_resp_idx = r_resp_idx + 4'd1;
                        end
                    end

                    if (done) begin
                        n_pend_kind = PK_NONE;
                        n_resp_idx  = 4'd0;
                    end

                    push.valid      = word_out || done;
                    push.cmd.opd    = {r_hold, i_in_data.rx_byte};
                    push.cmd.status = n_err;
                    push.cmd.exc    = (n_err == STAT_EXC) ? n_exc : 8'h00;
                    if (word_out && done) begin
                        push.cmd.op = OP_WORD_STATUS;
                    end else if (word_out) begin
                        push.cmd.op = OP_WORD;
                    end else begin
                        push.cmd.op = OP_STATUS;
                    end
                end
            end
            default: begin
            end
        endcase

        if (!accept) begin
            push.valid = 1'b0;
        end
    end

    assign o_push = push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit_id    <= 8'd1;
            r_next_tid   <= 16'd0;
            r_pend_tid   <= 16'd0;
            r_pend_kind  <= PK_NONE;
            r_exp_words  <= 7'd0;
            r_resp_idx   <= 4'd0;
            r_err        <= STAT_OK;
            r_exc        <= 8'h00;
            r_hold       <= 8'h00;
            r_words_left <= 7'd0;
        end else begin
            if (i_cfg_valid) begin
                r_unit_id <= i_cfg_data;
            end
            if (accept) begin
                r_next_tid   <= n_next_tid;
                r_pend_tid   <= n_pend_tid;
                r_pend_kind  <= n_pend_kind;
                r_exp_words  <= n_exp_words;
                r_resp_idx   <= n_resp_idx;
                r_err        <= n_err;
                r_exc        <= n_exc;
                r_hold       <= n_hold;
                r_words_left <= n_words_left;
            end
        end
    end

endmodule

[src/mbtf_queue.sv]
module mbtf_queue #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mbtf_pkg::t_push i_push,
    output logic            o_full,
    output mbtf_pkg::t_head o_head,
    input  logic            i_pop
);
    import mbtf_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full      = (r_cnt == CW'(DEPTH));
    assign o_head.valid = (r_cnt != '0);
    assign o_head.cmd  = r_mem[r_rd];
    assign do_push     = i_push.valid && !o_full;
    assign do_pop      = i_pop && o_head.valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push.cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

[src/mbtf_back.sv]
module mbtf_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mbtf_pkg::t_head   i_head,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output mbtf_pkg::t_result o_out_data
);
    import mbtf_pkg::*;

    logic [3:0]  r_idx;
    logic [3:0]  final_idx;
    logic        r_out_valid;
    t_result     r_out_data;
    t_result     n_out_data;
    logic        load;
    logic [15:0] frame_len;
    logic [7:0]  fc;
    t_cmd        cmd;

    assign cmd  = i_head.cmd;
    assign load = i_head.valid && (!r_out_valid || !i_out_stall);

    // Write multiple carries its byte count in the length field as well.
    assign frame_len = (cmd.op == OP_WR_MULTI) ?
                       16'd7 + {cmd.opd[14:0], 1'b0} : 16'd6;

    always_comb begin
        case (cmd.op)
            OP_READ:      fc = FC_READ_HOLDING;
            OP_WR_SINGLE: fc = FC_WRITE_SINGLE;
            default:      fc = FC_WRITE_MULTI;
        endcase
    end

    always_comb begin
        n_out_data = '0;
        final_idx  = 4'd0;
        case (cmd.op)
            OP_READ, OP_WR_SINGLE, OP_WR_MULTI: begin
                n_out_data.kind = KIND_TX;
                final_idx = (cmd.op == OP_WR_MULTI) ? 4'd12 : 4'd11;
                case (r_idx)
                    4'd0:    n_out_data.tx_byte = cmd.tid[15:8];
                    4'd1:    n_out_data.tx_byte = cmd.tid[7:0];
                    4'd4:    n_out_data.tx_byte = frame_len[15:8];
                    4'd5:    n_out_data.tx_byte = frame_len[7:0];
                    4'd6:    n_out_data.tx_byte = cmd.unit_id;
                    4'd7:    n_out_data.tx_byte = fc;
                    4'd8:    n_out_data.tx_byte = cmd.addr[15:8];
                    4'd9:    n_out_data.tx_byte = cmd.addr[7:0];
                    4'd10:   n_out_data.tx_byte = cmd.opd[15:8];
                    4'd11:   n_out_data.tx_byte = cmd.opd[7:0];
                    4'd12:   n_out_data.tx_byte = {cmd.opd[6:0], 1'b0};
                    default: n_out_data.tx_byte = 8'h00;
                endcase
                // The multiple-write header never ends a frame; its data words do.
                n_out_data.last = (cmd.op != OP_WR_MULTI) && (r_idx == 4'd11);
            end
            OP_DATA: begin
                final_idx          = 4'd1;
                n_out_data.kind    = KIND_TX;
                n_out_data.tx_byte = (r_idx == 4'd0) ? cmd.opd[15:8] : cmd.opd[7:0];
                n_out_data.last    = (r_idx != 4'd0) && cmd.last;
            end
            OP_WORD: begin
                n_out_data.kind     = KIND_WORD;
                n_out_data.reg_word = cmd.opd;
            end
            OP_WORD_STATUS: begin
                final_idx = 4'd1;
                if (r_idx == 4'd0) begin
                    n_out_data.kind     = KIND_WORD;
                    n_out_data.reg_word = cmd.opd;
                end else begin
                    n_out_data.kind           = KIND_STATUS;
                    n_out_data.status         = cmd.status;
                    n_out_data.exception_code = cmd.exc;
                    n_out_data.last           = 1'b1;
                end
            end
            default: begin
                n_out_data.kind           = KIND_STATUS;
                n_out_data.status         = cmd.status;
                n_out_data.exception_code = cmd.exc;
                n_out_data.last           = 1'b1;
            end
        endcase
    end

    assign o_pop       = load && (r_idx == final_idx);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= 4'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_idx       <= (r_idx == final_idx) ? 4'd0 : r_idx + 4'd1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

[src/modbus_tcp_master_framer_unit.sv]
// Modbus TCP client framer.
// Input channel (i_in_valid / o_in_stall / i_in_data): request items (read holding,
// write single, write multiple header), data words of a write multiple, and response
// bytes. An item is taken at any edge with valid high and stall low.
// Output channel (o_out_valid / i_out_stall / o_out_data): one result per cycle while unstalled:
// request frame bytes, read register words and a completion status.
// Configuration channel (i_cfg_valid / o_cfg_ready / i_cfg_data) writes the unit id;
// it is always ready; the unit id must be written only while the block is idle, as the block does not enforce it.
// The front end decodes each item and updates the transaction and response tracking in
// the cycle it is accepted, then queues at most one command. The back end expands a command
// into its results: 12 or 13 bytes for a request frame, two for a data word, one or two for
// a response byte. Each command passes through the queue and then the back end's result register.
// Items are taken one per cycle while the command queue has room; output bandwidth of one
// result per cycle while unstalled sets the sustained rate, so a request frame holds the output
// for all of its 12 or 13 bytes. A stall on the output holds the result register; the queue
// then fills and o_in_stall rises. Reset clears the transaction counter, the response
// tracking and the queue, and sets the unit id to 1.
module modbus_tcp_master_framer_unit #(
    parameter int MAX_READ_REGS  = 125,
    parameter int MAX_WRITE_REGS = 123,
    parameter int QUEUE_DEPTH    = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic [7:0]        i_cfg_data,
    output logic              o_cfg_ready,
    input  logic              i_in_valid,
    input  mbtf_pkg::t_item   i_in_data,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output mbtf_pkg::t_result o_out_data
);
    import mbtf_pkg::*;

    t_push push;
    t_head head;
    logic  full;
    logic  pop;

    mbtf_front #(
        .MAX_READ_REGS  (MAX_READ_REGS),
        .MAX_WRITE_REGS (MAX_WRITE_REGS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .i_full      (full),
        .o_push      (push)
    );

    mbtf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .o_head  (head),
        .i_pop   (pop)
    );

    mbtf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push.valid && full))
        else $error("command pushed into a full queue");

    a_request_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_data.mode == MODE_READ &&
         i_in_data.operand != 16'd0 &&
         i_in_data.operand <= 16'(MAX_READ_REGS))
        |-> (push.valid && push.cmd.op == OP_READ))
        else $error("accepted read request produced no frame command");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.kind == KIND_STATUS) |-> o_out_data.last)
        else $error("completion status without last");

    a_exc_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.exception_code != 8'h00)
        |-> (o_out_data.kind == KIND_STATUS && o_out_data.status == STAT_EXC))
        else $error("exception code outside an exception status");

endmodule
